// File: design/akf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akf_pkg
// Shared types, constants and the micro-program of the altitude Kalman filter.
// ----------------------------------------------------------------------------
package akf_pkg;

  localparam int STATE_COUNT = 3;

  // Configuration register indexes and width.
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_NOISE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BARO_NOISE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GPSP_NOISE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GPSV_NOISE  = 3'd4;

  localparam logic [CFG_W-1:0] CFG_ACCEL_RST = 31'd65536;
  localparam logic [CFG_W-1:0] CFG_BIAS_RST  = 31'd655;
  localparam logic [CFG_W-1:0] CFG_MEAS_RST  = 31'd65536;

  // Fixed-point constants (Q16.16).
  localparam logic [31:0] FX_HALF    = 32'd32768;
  localparam logic [31:0] FX_INIT_P0 = 32'd327680;
  localparam logic [31:0] FX_INIT_P1 = 32'd131072;
  localparam logic [31:0] FX_INIT_P2 = 32'd655;
  localparam logic [31:0] FX_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] FX_MIN     = 32'h8000_0000;
  localparam logic [15:0] DT_MIN     = 16'd66;
  localparam logic [15:0] DT_MAX     = 16'd6553;

  // Divider sizing: a 32-bit dividend scaled by 2^16.
  localparam int DIV_BITS  = 48;
  localparam int DIV_CNT_W = 6;

  // Scratch memory layout.
  localparam int MEM_DEPTH = 32;
  localparam int MEM_AW    = 5;
  localparam logic [5:0] X0  = 6'd0;
  localparam logic [5:0] X1  = 6'd1;
  localparam logic [5:0] X2  = 6'd2;
  localparam logic [5:0] P00 = 6'd3;
  localparam logic [5:0] P01 = 6'd4;
  localparam logic [5:0] P02 = 6'd5;
  localparam logic [5:0] P10 = 6'd6;
  localparam logic [5:0] P11 = 6'd7;
  localparam logic [5:0] P12 = 6'd8;
  localparam logic [5:0] P20 = 6'd9;
  localparam logic [5:0] P21 = 6'd10;
  localparam logic [5:0] P22 = 6'd11;
  localparam logic [5:0] T0  = 6'd12;
  localparam logic [5:0] T4  = 6'd16;
  localparam logic [5:0] T8  = 6'd20;
  localparam logic [5:0] W0  = 6'd21;
  localparam logic [5:0] W1  = 6'd22;
  localparam logic [5:0] W2  = 6'd23;
  localparam logic [5:0] W3  = 6'd24;
  localparam logic [5:0] W4  = 6'd25;
  localparam logic [5:0] W5  = 6'd26;
  localparam logic [5:0] W6  = 6'd27;
  localparam logic [5:0] W7  = 6'd28;
  localparam logic [5:0] W8  = 6'd29;

  // Operand codes with bit 5 set select a non-memory source.
  localparam logic [5:0] SP_ZERO = 6'd32;
  localparam logic [5:0] SP_DT   = 6'd33;
  localparam logic [5:0] SP_ACC  = 6'd34;
  localparam logic [5:0] SP_HALF = 6'd35;
  localparam logic [5:0] SP_CFG0 = 6'd36;
  localparam logic [5:0] SP_CFG1 = 6'd37;
  localparam logic [5:0] SP_CFG2 = 6'd38;
  localparam logic [5:0] SP_CFG3 = 6'd39;
  localparam logic [5:0] SP_CFG4 = 6'd40;
  localparam logic [5:0] SP_BARO = 6'd41;
  localparam logic [5:0] SP_GPSP = 6'd42;
  localparam logic [5:0] SP_GPSV = 6'd43;
  localparam logic [5:0] SP_ALT  = 6'd44;
  localparam logic [5:0] SP_PC0  = 6'd45;
  localparam logic [5:0] SP_PC1  = 6'd46;
  localparam logic [5:0] SP_PC2  = 6'd47;

  // Program entry points.
  localparam logic [7:0] PC_INIT   = 8'd0;
  localparam logic [7:0] PC_UPDATE = 8'd13;
  localparam logic [7:0] PC_BARO   = 8'd67;
  localparam logic [7:0] PC_FUSE_B = 8'd68;
  localparam logic [7:0] PC_FUSE_P = 8'd97;
  localparam logic [7:0] PC_FUSE_V = 8'd126;
  localparam logic [7:0] PC_LAST   = 8'd154;

  typedef enum logic [2:0] {
    OP_END, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DEN
  } op_t;

  typedef enum logic [1:0] {G_ALL, G_BARO, G_GPS} grp_t;

  typedef struct packed {
    op_t        op;
    grp_t       grp;
    logic       cond;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] d;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_WRITE, ST_DONE
  } state_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] quot;
  } div_res_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } satv_t;

  // Clamp a 33-bit sum to the signed 32-bit range.
  function automatic satv_t sat33(input logic [32:0] s);
    satv_t r;
    r.sat = s[32] ^ s[31];
    r.val = r.sat ? (s[32] ? FX_MIN : FX_MAX) : s[31:0];
    return r;
  endfunction

  // Clamp a 64-bit value to the signed 32-bit range.
  function automatic satv_t sat64(input logic [63:0] s);
    satv_t r;
    r.sat = !((&s[63:31]) || !(|s[63:31]));
    r.val = r.sat ? (s[63] ? FX_MIN : FX_MAX) : s[31:0];
    return r;
  endfunction

  function automatic uop_t mk(input op_t op, input grp_t g, input logic c,
                              input logic [5:0] a, input logic [5:0] b,
                              input logic [5:0] d);
    uop_t u;
    u.op = op; u.grp = g; u.cond = c; u.a = a; u.b = b; u.d = d;
    return u;
  endfunction

  // Address of covariance entry (r, c).
  function automatic logic [5:0] pad(input logic [1:0] r, input logic [1:0] c);
    return P00 + 6'(r) * 6'd3 + 6'(c);
  endfunction

  // One step of a scalar fusion on state m, done in place on the covariance.
  // Rows other than m are updated first so row m is still intact for them.
  function automatic uop_t fuse_uop(input logic [4:0] idx, input logic [1:0] m,
                                    input logic [5:0] z, input logic [5:0] r,
                                    input grp_t g);
    uop_t       u;
    logic [4:0] e;
    logic [4:0] f;
    logic [1:0] k;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] row;
    u = mk(OP_END, G_ALL, 1'b0, SP_ZERO, SP_ZERO, W3);
    e = 5'd0; f = 5'd0; k = 2'd0; i = 2'd0; j = 2'd0; row = 2'd0;
    if (idx == 5'd0) begin
      u = mk(OP_DEN, g, 1'b0, pad(m, m), r, W5);
    end else if (idx == 5'd1) begin
      u = mk(OP_SUB, g, 1'b1, z, X0 + 6'(m), W6);
    end else if (idx <= 5'd4) begin
      i = 2'(idx - 5'd2);
      u = mk(OP_DIV, g, 1'b1, pad(i, m), W5, W8 + 6'(i));
    end else if (idx <= 5'd10) begin
      e = idx - 5'd5;
      i = e[2:1];
      if (!e[0]) u = mk(OP_MUL, g, 1'b1, W8 + 6'(i), W6, W3);
      else       u = mk(OP_ADD, g, 1'b1, X0 + 6'(i), W3, X0 + 6'(i));
    end else if (idx <= 5'd28) begin
      e = idx - 5'd11;
      k = (e < 5'd6) ? 2'd0 : ((e < 5'd12) ? 2'd1 : 2'd2);
      f = e - 5'(k) * 5'd6;
      j = f[2:1];
      row = (k == 2'd2) ? m : ((k < m) ? k : k + 2'd1);
      if (!f[0]) u = mk(OP_MUL, g, 1'b1, W8 + 6'(row), pad(m, j), W3);
      else       u = mk(OP_SUB, g, 1'b1, pad(row, j), W3, pad(row, j));
    end
    return u;
  endfunction

  // Micro-program: init, predict, then the three optional fusions.
  function automatic uop_t prog_rom(input logic [7:0] pc);
    uop_t u;
    u = mk(OP_END, G_ALL, 1'b0, SP_ZERO, SP_ZERO, W3);
    if (pc < PC_BARO) begin
      case (pc)
        // Initialization from altitude.
        8'd0:  u = mk(OP_SUB, G_ALL, 1'b0, SP_ZERO, SP_ALT, X0);
        8'd1:  u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_ZERO, X1);
        8'd2:  u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_ZERO, X2);
        8'd3:  u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_PC0, P00);
        8'd4:  u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_ZERO, P01);
        8'd5:  u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_ZERO, P02);
        8'd6:  u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_ZERO, P10);
        8'd7:  u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_PC1, P11);
        8'd8:  u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_ZERO, P12);
        8'd9:  u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_ZERO, P20);
        8'd10: u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_ZERO, P21);
        8'd11: u = mk(OP_ADD, G_ALL, 1'b0, SP_ZERO, SP_PC2, P22);
        8'd12: u = mk(OP_END, G_ALL, 1'b0, SP_ZERO, SP_ZERO, W3);
        // State prediction.
        8'd13: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, SP_DT, W0);
        8'd14: u = mk(OP_SUB, G_ALL, 1'b0, SP_ACC, X2, W1);
        8'd15: u = mk(OP_MUL, G_ALL, 1'b0, W1, W0, W2);
        8'd16: u = mk(OP_MUL, G_ALL, 1'b0, W2, SP_HALF, W2);
        8'd17: u = mk(OP_MUL, G_ALL, 1'b0, X1, SP_DT, W3);
        8'd18: u = mk(OP_ADD, G_ALL, 1'b0, W3, W2, W3);
        8'd19: u = mk(OP_ADD, G_ALL, 1'b0, X0, W3, X0);
        8'd20: u = mk(OP_MUL, G_ALL, 1'b0, W1, SP_DT, W3);
        8'd21: u = mk(OP_ADD, G_ALL, 1'b0, X1, W3, X1);
        // Covariance prediction into the T block.
        8'd22: u = mk(OP_ADD, G_ALL, 1'b0, P01, P10, W3);
        8'd23: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, P11, W4);
        8'd24: u = mk(OP_ADD, G_ALL, 1'b0, W3, W4, W3);
        8'd25: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, W3, W3);
        8'd26: u = mk(OP_ADD, G_ALL, 1'b0, P00, W3, T0);
        8'd27: u = mk(OP_SUB, G_ALL, 1'b0, P11, P02, W3);
        8'd28: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, P12, W4);
        8'd29: u = mk(OP_SUB, G_ALL, 1'b0, W3, W4, W3);
        8'd30: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, W3, W3);
        8'd31: u = mk(OP_ADD, G_ALL, 1'b0, P01, W3, T0 + 6'd1);
        8'd32: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, P12, W3);
        8'd33: u = mk(OP_ADD, G_ALL, 1'b0, P02, W3, T0 + 6'd2);
        8'd34: u = mk(OP_SUB, G_ALL, 1'b0, P11, P20, W3);
        8'd35: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, P21, W4);
        8'd36: u = mk(OP_SUB, G_ALL, 1'b0, W3, W4, W3);
        8'd37: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, W3, W3);
        8'd38: u = mk(OP_ADD, G_ALL, 1'b0, P10, W3, T0 + 6'd3);
        8'd39: u = mk(OP_SUB, G_ALL, 1'b0, SP_ZERO, P21, W3);
        8'd40: u = mk(OP_SUB, G_ALL, 1'b0, W3, P12, W3);
        8'd41: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, P22, W4);
        8'd42: u = mk(OP_ADD, G_ALL, 1'b0, W3, W4, W3);
        8'd43: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, W3, W3);
        8'd44: u = mk(OP_ADD, G_ALL, 1'b0, P11, W3, T4);
        8'd45: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, P22, W3);
        8'd46: u = mk(OP_SUB, G_ALL, 1'b0, P12, W3, T0 + 6'd5);
        8'd47: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, P21, W3);
        8'd48: u = mk(OP_ADD, G_ALL, 1'b0, P20, W3, T0 + 6'd6);
        8'd49: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, P22, W3);
        8'd50: u = mk(OP_SUB, G_ALL, 1'b0, P21, W3, T0 + 6'd7);
        8'd51: u = mk(OP_ADD, G_ALL, 1'b0, P22, SP_ZERO, T8);
        // Process noise.
        8'd52: u = mk(OP_MUL, G_ALL, 1'b0, SP_HALF, W0, W3);
        8'd53: u = mk(OP_MUL, G_ALL, 1'b0, W3, SP_CFG0, W3);
        8'd54: u = mk(OP_ADD, G_ALL, 1'b0, T0, W3, T0);
        8'd55: u = mk(OP_MUL, G_ALL, 1'b0, SP_DT, SP_CFG0, W3);
        8'd56: u = mk(OP_ADD, G_ALL, 1'b0, T4, W3, T4);
        8'd57: u = mk(OP_ADD, G_ALL, 1'b0, T8, SP_CFG1, T8);
        default: begin
          // Copy the predicted covariance back, one entry per step.
          u = mk(OP_ADD, G_ALL, 1'b0, T0 + 6'(pc - 8'd58), SP_ZERO,
                 P00 + 6'(pc - 8'd58));
        end
      endcase
    end else if (pc == PC_BARO) begin
      u = mk(OP_SUB, G_BARO, 1'b0, SP_ZERO, SP_BARO, W7);
    end else if (pc < PC_FUSE_P) begin
      u = fuse_uop(5'(pc - PC_FUSE_B), 2'd0, W7, SP_CFG2, G_BARO);
    end else if (pc < PC_FUSE_V) begin
      u = fuse_uop(5'(pc - PC_FUSE_P), 2'd0, SP_GPSP, SP_CFG3, G_GPS);
    end else if (pc <= PC_LAST) begin
      u = fuse_uop(5'(pc - PC_FUSE_V), 2'd1, SP_GPSV, SP_CFG4, G_GPS);
    end
    return u;
  endfunction

endpackage

// File: design/akf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// akf_div
// Radix-2 restoring divider for the Q16.16 quotient (a * 2^16) / b.
// ----------------------------------------------------------------------------
module akf_div
  import akf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num_a,
  input  logic [31:0] den_b,
  output div_res_t    res
);

  logic                    busy;
  logic                    done;
  logic                    neg;
  logic [DIV_CNT_W-1:0]    count;
  logic [DIV_BITS-1:0]     num;
  logic [32:0]             rem;
  logic [31:0]             den;
  logic [31:0]             abs_a;
  logic [31:0]             abs_b;
  logic [32:0]             rem_sh;
  logic                    ge;

  assign abs_a  = num_a[31] ? (~num_a + 32'd1) : num_a;
  assign abs_b  = den_b[31] ? (~den_b + 32'd1) : den_b;
  assign rem_sh = {rem[31:0], num[DIV_BITS-1]};
  assign ge     = rem_sh >= {1'b0, den};

  // One quotient bit per cycle; the dividend register fills with the quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den_b == 32'd0) begin
          num  <= '0;
          neg  <= 1'b0;
          done <= 1'b1;
        end else begin
          num   <= {abs_a, 16'h0000};
          rem   <= '0;
          den   <= abs_b;
          neg   <= num_a[31] ^ den_b[31];
          count <= DIV_CNT_W'(DIV_BITS);
          busy  <= 1'b1;
        end
      end else if (busy) begin
        rem   <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
        num   <= {num[DIV_BITS-2:0], ge};
        count <= count - DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign and clamp of the finished quotient.
  always_comb begin
    res.done = done;
    if (neg) begin
      res.sat  = (|num[DIV_BITS-1:32]) || (num[31] && (|num[30:0]));
      res.quot = res.sat ? FX_MIN : (~num[31:0] + 32'd1);
    end else begin
      res.sat  = |num[DIV_BITS-1:31];
      res.quot = res.sat ? FX_MAX : num[31:0];
    end
  end

endmodule

// File: design/altitude_kalman_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_kalman_filter_top
// Three-state vertical Kalman filter (position, velocity, accel bias) run by
// a micro-sequencer over a scratch memory with a shared multiplier and divider.
// ----------------------------------------------------------------------------
// Channel   Direction  Word contents
// s_*       in         one init or update request
// m_*       out        state estimate and flags after that request
// cfg_*     in         noise variance register writes
//
// Each micro-op reads two operands from the memory through registered read
// ports, then passes EXEC and WRITE for add/subtract, with a MUL state added
// for multiply and a wait in DIV on the divider for divide; gated-off
// micro-ops are stepped over in READ. A skipped step goes from IDLE straight
// to DONE. Reset clears the state via per-entry valid bits, so no clearing
// pass is needed. A waiting result does not block the next request from
// being taken.
// ----------------------------------------------------------------------------
module altitude_kalman_filter_top
  import akf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // init_altitude, accel, time_step, baro_altitude, gps_down_position,
  // gps_down_velocity
  input  logic [175:0]         s_tdata,
  // opcode, baro_valid, gps_valid
  input  logic [2:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // est_position, est_velocity, est_bias
  output logic [95:0]          m_tdata,
  // step_skipped, saturated
  output logic [1:0]           m_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t state, state_next;
  logic [7:0]  pc;
  uop_t        uop;
  logic        gate_off;

  // Latched request.
  logic        in_baro, in_gps;
  logic [31:0] in_alt, in_acc, in_bar, in_gpsp, in_gpsv;
  logic [15:0] in_dt;
  logic        dt_bad;

  logic [CFG_W-1:0] cfg_accel, cfg_bias, cfg_baro, cfg_gpsp, cfg_gpsv;

  // Scratch memory with valid bits standing in for the zero reset.
  logic [31:0]          mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld;
  logic [31:0]          rda, rdb;
  logic                 rva, rvb;

  logic [31:0] opa, opb;
  logic [63:0] prod;
  logic [31:0] res;
  logic        res_sat;
  logic        sat_acc, den_skip, skipped;
  logic [31:0] est_pos, est_vel, est_bias;
  satv_t       add_r, sub_r, mul_r;
  logic [63:0] prod_rnd;
  div_res_t    div_r;
  logic        div_start;
  logic        out_free;

  assign uop      = prog_rom(pc);
  assign dt_bad   = (s_tdata[79:64] < DT_MIN) || (s_tdata[79:64] > DT_MAX);
  assign gate_off = (uop.grp == G_BARO && !in_baro) || (uop.grp == G_GPS && !in_gps) ||
                    (uop.cond && den_skip);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign div_start = (state == ST_EXEC) && (uop.op == OP_DIV);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_accel <= CFG_ACCEL_RST;
      cfg_bias  <= CFG_BIAS_RST;
      cfg_baro  <= CFG_MEAS_RST;
      cfg_gpsp  <= CFG_MEAS_RST;
      cfg_gpsv  <= CFG_MEAS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEL_NOISE: cfg_accel <= cfg_data;
        CFG_BIAS_NOISE:  cfg_bias  <= cfg_data;
        CFG_BARO_NOISE:  cfg_baro  <= cfg_data;
        CFG_GPSP_NOISE:  cfg_gpsp  <= cfg_data;
        CFG_GPSV_NOISE:  cfg_gpsv  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection: memory data or one of the fixed sources.
  function automatic logic [31:0] pick(input logic [5:0] code, input logic [31:0] md,
                                       input logic mv);
    logic [31:0] v;
    v = 32'd0;
    if (!code[5]) begin
      v = mv ? md : 32'd0;
    end else begin
      case (code)
        SP_DT:   v = {16'd0, in_dt};
        SP_ACC:  v = in_acc;
        SP_HALF: v = FX_HALF;
        SP_CFG0: v = {1'b0, cfg_accel};
        SP_CFG1: v = {1'b0, cfg_bias};
        SP_CFG2: v = {1'b0, cfg_baro};
        SP_CFG3: v = {1'b0, cfg_gpsp};
        SP_CFG4: v = {1'b0, cfg_gpsv};
        SP_BARO: v = in_bar;
        SP_GPSP: v = in_gpsp;
        SP_GPSV: v = in_gpsv;
        SP_ALT:  v = in_alt;
        SP_PC0:  v = FX_INIT_P0;
        SP_PC1:  v = FX_INIT_P1;
        SP_PC2:  v = FX_INIT_P2;
        default: v = 32'd0;
      endcase
    end
    return v;
  endfunction

  assign opa      = pick(uop.a, rda, rva);
  assign opb      = pick(uop.b, rdb, rvb);
  assign add_r    = sat33({opa[31], opa} + {opb[31], opb});
  assign sub_r    = sat33({opa[31], opa} - {opb[31], opb});
  assign prod_rnd = prod + 64'd32768;
  assign mul_r    = sat64({{16{prod_rnd[63]}}, prod_rnd[63:16]});

  akf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_a (opa),
    .den_b (opb),
    .res   (div_r)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = (s_tuser[0] && dt_bad) ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        if (uop.op == OP_END) state_next = ST_DONE;
        else if (!gate_off)   state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (uop.op)
          OP_MUL:  state_next = ST_MUL;
          OP_DIV:  state_next = ST_DIV;
          default: state_next = ST_WRITE;
        endcase
      end
      ST_MUL:   state_next = ST_WRITE;
      ST_DIV:   if (div_r.done) state_next = ST_WRITE;
      ST_WRITE: state_next = ST_READ;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory read ports, registered.
  always_ff @(posedge clk) begin
    rda <= mem[uop.a[MEM_AW-1:0]];
    rdb <= mem[uop.b[MEM_AW-1:0]];
    rva <= vld[uop.a[MEM_AW-1:0]];
    rvb <= vld[uop.b[MEM_AW-1:0]];
    if (state == ST_WRITE) mem[uop.d[MEM_AW-1:0]] <= res;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst)                    vld <= '0;
    else if (state == ST_WRITE) vld[uop.d[MEM_AW-1:0]] <= 1'b1;
  end

  // Request latch and datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          in_alt  <= s_tdata[31:0];
          in_acc  <= s_tdata[63:32];
          in_dt   <= s_tdata[79:64];
          in_bar  <= s_tdata[111:80];
          in_gpsp <= s_tdata[143:112];
          in_gpsv <= s_tdata[175:144];
          in_baro <= s_tuser[1];
          in_gps  <= s_tuser[2];
          pc      <= s_tuser[0] ? PC_UPDATE : PC_INIT;
          skipped <= s_tuser[0] && dt_bad;
          sat_acc <= 1'b0;
        end
      end
      ST_READ: begin
        if (uop.op != OP_END && gate_off) pc <= pc + 8'd1;
      end
      ST_EXEC: begin
        prod <= 64'($signed(opa) * $signed(opb));
        if (uop.op == OP_SUB) begin
          res     <= sub_r.val;
          res_sat <= sub_r.sat;
        end else begin
          res     <= add_r.val;
          res_sat <= add_r.sat;
        end
      end
      ST_MUL: begin
        res     <= mul_r.val;
        res_sat <= mul_r.sat;
      end
      ST_DIV: begin
        if (div_r.done) begin
          res     <= div_r.quot;
          res_sat <= div_r.sat;
        end
      end
      ST_WRITE: begin
        pc      <= pc + 8'd1;
        sat_acc <= sat_acc | res_sat;
        if (uop.op == OP_DEN) den_skip <= res[31] || (res == 32'd0);
      end
      default: ;
    endcase
  end

  // Shadow of the state vector for the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      est_pos  <= '0;
      est_vel  <= '0;
      est_bias <= '0;
    end else if (state == ST_WRITE) begin
      case (uop.d)
        X0:      est_pos  <= res;
        X1:      est_vel  <= res;
        X2:      est_bias <= res;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {est_bias, est_vel, est_pos};
        m_tuser  <= {sat_acc && !skipped, skipped};
      end
    end
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the altitude Kalman filter. A directed table covers
// init extremes, out-of-range steps and every fusion mix. Random phases follow:
// mostly init-then-track sequences under several noise settings, with some
// garbage words and skipped steps mixed in. Every accepted request runs through
// a fixed-point filter model kept in the bench, and each result word is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import akf_pkg::*;

  localparam bit OPC_INIT   = 1'b0;
  localparam bit OPC_UPDATE = 1'b1;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 4000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic        opcode;
    logic [31:0] alt;
    logic [31:0] accel;
    logic [15:0] dt;
    logic        baro_v;
    logic [31:0] baro;
    logic        gps_v;
    logic [31:0] gps_pos;
    logic [31:0] gps_vel;
  } req_t;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] bias;
    logic        skipped;
    logic        sat;
  } est_t;

  typedef struct packed {
    req_t req;
    logic chk;
    est_t want;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [175:0]         s_tdata;
  logic [2:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [95:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  altitude_kalman_filter_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Filter model state: estimate, covariance (row major) and noise variances.
  longint est_x[3];
  longint est_p[9];
  longint est_pn[9];
  longint noise_var[5];
  bit     step_sat;

  est_t   est_q[$];
  row_t   dir_rows[$];
  int     errors;
  int     idle_cycles;
  int     hold_seq;
  int     rx_mode;
  bit     gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point model
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(input longint v);
    if (v > Q_MAX) begin
      step_sat = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      step_sat = 1'b1;
      return Q_MIN;
    end
    return v;
  endfunction

  function automatic longint qadd(input longint a, input longint b);
    return clamp32(a + b);
  endfunction

  function automatic longint qsub(input longint a, input longint b);
    return clamp32(a - b);
  endfunction

  // Rounded product; the arithmetic shift floors toward minus infinity.
  function automatic longint qmul(input longint a, input longint b);
    return clamp32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint qdiv(input longint a, input longint b);
    if (b == 0) return 0;
    return clamp32((a * 64'sd65536) / b);
  endfunction

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Scalar measurement fusion of state m; a non-positive innovation
  // variance leaves everything untouched.
  function automatic void fuse_meas(input int m, input longint z, input longint r);
    longint den;
    longint y;
    longint k[3];
    den = qadd(est_p[m*3+m], r);
    if (den <= 0) return;
    y = qsub(z, est_x[m]);
    for (int i = 0; i < 3; i++) k[i] = qdiv(est_p[i*3+m], den);
    for (int i = 0; i < 3; i++) est_x[i] = qadd(est_x[i], qmul(k[i], y));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        est_pn[i*3+j] = qsub(est_p[i*3+j], qmul(k[i], est_p[m*3+j]));
    for (int i = 0; i < 9; i++) est_p[i] = est_pn[i];
  endfunction

  function automatic est_t filter_step(input req_t rq);
    est_t   o;
    longint dt;
    longint dt2;
    longint acc;
    longint half_a;
    longint t[9];
    bit     skip;
    skip = 1'b0;
    step_sat = 1'b0;
    dt = longint'(rq.dt);
    if (rq.opcode == OPC_INIT) begin
      est_x[0] = clamp32(-sx(rq.alt));
      est_x[1] = 0;
      est_x[2] = 0;
      for (int i = 0; i < 9; i++) est_p[i] = 0;
      est_p[0] = longint'(FX_INIT_P0);
      est_p[4] = longint'(FX_INIT_P1);
      est_p[8] = longint'(FX_INIT_P2);
    end else if (dt < longint'(DT_MIN) || dt > longint'(DT_MAX)) begin
      skip = 1'b1;
    end else begin
      dt2 = qmul(dt, dt);
      acc = qsub(sx(rq.accel), est_x[2]);
      half_a = qmul(qmul(acc, dt2), longint'(FX_HALF));
      est_x[0] = qadd(est_x[0], qadd(qmul(est_x[1], dt), half_a));
      est_x[1] = qadd(est_x[1], qmul(acc, dt));

      t[0] = qadd(est_p[0], qmul(dt, qadd(qadd(est_p[1], est_p[3]), qmul(dt, est_p[4]))));
      t[1] = qadd(est_p[1], qmul(dt, qsub(qsub(est_p[4], est_p[2]), qmul(dt, est_p[5]))));
      t[2] = qadd(est_p[2], qmul(dt, est_p[5]));
      t[3] = qadd(est_p[3], qmul(dt, qsub(qsub(est_p[4], est_p[6]), qmul(dt, est_p[7]))));
      t[4] = qadd(est_p[4], qmul(dt, qadd(qsub(clamp32(-est_p[7]), est_p[5]),
                                          qmul(dt, est_p[8]))));
      t[5] = qsub(est_p[5], qmul(dt, est_p[8]));
      t[6] = qadd(est_p[6], qmul(dt, est_p[7]));
      t[7] = qsub(est_p[7], qmul(dt, est_p[8]));
      t[8] = est_p[8];

      // Process noise on the diagonal.
      t[0] = qadd(t[0], qmul(qmul(longint'(FX_HALF), dt2), noise_var[0]));
      t[4] = qadd(t[4], qmul(dt, noise_var[0]));
      t[8] = qadd(t[8], noise_var[1]);
      for (int i = 0; i < 9; i++) est_p[i] = t[i];

      if (rq.baro_v) fuse_meas(0, clamp32(-sx(rq.baro)), noise_var[2]);
      if (rq.gps_v) begin
        fuse_meas(0, sx(rq.gps_pos), noise_var[3]);
        fuse_meas(1, sx(rq.gps_vel), noise_var[4]);
      end
    end
    o.pos = est_x[0][31:0];
    o.vel = est_x[1][31:0];
    o.bias = est_x[2][31:0];
    o.skipped = skip;
    o.sat = !skip && step_sat;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic req_t mk_req(input logic op, input logic [31:0] alt,
                                  input logic [31:0] accel, input logic [15:0] dt,
                                  input logic bv, input logic [31:0] baro,
                                  input logic gv, input logic [31:0] gp,
                                  input logic [31:0] gvel);
    req_t r;
    r.opcode = op; r.alt = alt; r.accel = accel; r.dt = dt;
    r.baro_v = bv; r.baro = baro; r.gps_v = gv; r.gps_pos = gp; r.gps_vel = gvel;
    return r;
  endfunction

  function automatic est_t mk_est(input logic [31:0] p, input logic [31:0] v,
                                  input logic [31:0] b, input logic sk,
                                  input logic st);
    est_t e;
    e.pos = p; e.vel = v; e.bias = b; e.skipped = sk; e.sat = st;
    return e;
  endfunction

  // Signed offset of up to span metres, in Q16.16.
  function automatic longint jitter(input int span);
    return longint'($urandom_range(0, 2 * span * 65536)) - longint'(span) * 65536;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    r = mk_req(OPC_UPDATE, $urandom, $urandom, 16'($urandom), $urandom_range(0, 1),
               $urandom, $urandom_range(0, 1), $urandom, $urandom);
    if (pick < 5) begin
      r.opcode = OPC_INIT;
      r.alt = 32'(jitter(2000));
    end else if (pick < 12) begin
      // Garbage word: every field fully random.
      r.opcode = 1'($urandom);
    end else if (pick < 18) begin
      r.dt = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 65))
                                         : 16'($urandom_range(6554, 65535));
    end else begin
      // Tracking update with measurements close to the current estimate.
      r.dt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(66, 6553))
                                         : 16'($urandom_range(600, 1200));
      r.accel = 32'(longint'(642908) + jitter(20));
      r.baro_v = ($urandom_range(0, 1) != 0);
      r.gps_v = ($urandom_range(0, 4) < 2);
      r.baro = 32'(-est_x[0] + jitter(5));
      r.gps_pos = 32'(est_x[0] + jitter(5));
      r.gps_vel = 32'(est_x[1] + jitter(2));
    end
    return r;
  endfunction

  // Offer one request word, wait for the handshake, then record the prediction.
  task automatic send_req(input req_t rq, input bit chk, input est_t want);
    est_t got;
    s_tdata <= {rq.gps_vel, rq.gps_pos, rq.baro, rq.dt, rq.accel, rq.alt};
    s_tuser <= {rq.gps_v, rq.baro_v, rq.opcode};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    got = filter_step(rq);
    est_q.push_back(chk ? want : got);
    @(negedge clk);
  endtask

  task automatic send_gap();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 20)) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < 5) noise_var[idx] = longint'(val);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (est_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    est_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (est_q.size() == 0) begin
        report("unexpected word", {30'd0, m_tuser}, 32'd0);
      end else begin
        e = est_q.pop_front();
        if (m_tdata[31:0] !== e.pos) report("est_position", m_tdata[31:0], e.pos);
        if (m_tdata[63:32] !== e.vel) report("est_velocity", m_tdata[63:32], e.vel);
        if (m_tdata[95:64] !== e.bias) report("est_bias", m_tdata[95:64], e.bias);
        if (m_tuser[0] !== e.skipped) report("step_skipped", {31'd0, m_tuser[0]}, {31'd0, e.skipped});
        if (m_tuser[1] !== e.sat) report("saturated", {31'd0, m_tuser[1]}, {31'd0, e.sat});
      end
    end
  end

  // Watchdog on cycles where neither side moves a word and no configuration write is made.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver: per-phase stall pattern, plus a long hold-off on request.
  initial begin
    int hold_left;
    int seen_seq;
    int cyc;
    hold_left = 0;
    seen_seq = 0;
    cyc = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_seq != seen_seq) begin
        seen_seq = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_mode == 0) begin
        m_tready <= 1'b1;
      end else if (rx_mode == 1) begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        m_tready <= ((cyc % 7) >= 3);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    est_t  none;
    req_t  rq;
    int    burst;
    errors = 0;
    idle_cycles = 0;
    hold_seq = 0;
    rx_mode = 0;
    gaps_on = 1'b1;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    none = '0;
    for (int i = 0; i < 3; i++) est_x[i] = 0;
    for (int i = 0; i < 9; i++) est_p[i] = 0;
    noise_var[0] = longint'(CFG_ACCEL_RST);
    noise_var[1] = longint'(CFG_BIAS_RST);
    noise_var[2] = longint'(CFG_MEAS_RST);
    noise_var[3] = longint'(CFG_MEAS_RST);
    noise_var[4] = longint'(CFG_MEAS_RST);

    // Directed table; expected words are typed in only where obvious.
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 0, 16'd0, 0, 0, 0, 0, 0), 1'b1,
                        mk_est(0, 0, 0, 1, 0)});
    dir_rows.push_back({mk_req(OPC_INIT, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_est(32'h7fff_ffff, 0, 0, 0, 1)});
    dir_rows.push_back({mk_req(OPC_INIT, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_est(32'h8000_0001, 0, 0, 0, 0)});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 32'h1234, 16'd65, 1, 5, 1, 6, 7), 1'b1,
                        mk_est(32'h8000_0001, 0, 0, 1, 0)});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 0, 16'd6554, 1, 0, 0, 0, 0), 1'b1,
                        mk_est(32'h8000_0001, 0, 0, 1, 0)});
    dir_rows.push_back({mk_req(OPC_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 1,
                               32'hffff_ffff, 1, 32'hffff_ffff, 32'hffff_ffff), 1'b1,
                        mk_est(32'h8000_0001, 0, 0, 1, 0)});
    dir_rows.push_back({mk_req(OPC_INIT, 32'd6553600, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_est(32'hff9c_0000, 0, 0, 0, 0)});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 0, 16'd66, 0, 0, 0, 0, 0), 1'b0, none});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 32'h7fff_ffff, 16'd6553, 1, 32'd6553600,
                               0, 0, 0), 1'b0, none});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 0, 16'd655, 0, 0, 1, 32'hff9c_0000, 0),
                        1'b0, none});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 32'h8000_0000, 16'd655, 1, 32'h7fff_ffff,
                               1, 32'h8000_0000, 32'h7fff_ffff), 1'b0, none});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 32'h7fff_ffff, 16'd6553, 1, 32'h8000_0000,
                               1, 32'h7fff_ffff, 32'h8000_0000), 1'b0, none});
    dir_rows.push_back({mk_req(OPC_INIT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_est(0, 0, 0, 0, 0)});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 32'd642908, 16'd1000, 1, 32'hfffe_0000,
                               1, 32'd65536, 32'd6554), 1'b0, none});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 32'd642908, 16'd1000, 1, 32'd0,
                               0, 0, 0), 1'b0, none});
    dir_rows.push_back({mk_req(OPC_UPDATE, 0, 32'hfff6_0000, 16'd800, 0, 0,
                               1, 32'hffff_0000, 32'hfffe_0000), 1'b0, none});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    rx_mode <= 1;
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].want);
      if ($urandom_range(0, 2) == 0) send_gap();
    end

    // Random phases, each with a noise setting and receiver pattern chosen per phase.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        1: begin
          for (int i = 0; i < 5; i++) cfg_write(3'(i), 31'h7fff_ffff);
        end
        2: begin
          cfg_write(CFG_ACCEL_NOISE, 31'd0);
          cfg_write(CFG_BIAS_NOISE, 31'd0);
          cfg_write(CFG_BARO_NOISE, 31'd1);
          cfg_write(CFG_GPSP_NOISE, 31'd1);
          cfg_write(CFG_GPSV_NOISE, 31'd1);
        end
        3: begin
          cfg_write(CFG_ACCEL_NOISE, 31'($urandom));
          cfg_write(CFG_BIAS_NOISE, 31'($urandom));
          cfg_write(CFG_BARO_NOISE, 31'($urandom_range(1, 32'h7fff_ffff)));
          cfg_write(CFG_GPSP_NOISE, 31'($urandom_range(1, 32'h7fff_ffff)));
          cfg_write(CFG_GPSV_NOISE, 31'($urandom_range(1, 32'h7fff_ffff)));
        end
        4: begin
          // Writes to indexes past the register list must be ignored.
          for (int i = 5; i < 8; i++) cfg_write(3'(i), 31'($urandom));
          cfg_write(CFG_ACCEL_NOISE, 31'd65536);
          cfg_write(CFG_BIAS_NOISE, 31'd655);
        end
        default: begin
          cfg_write(CFG_ACCEL_NOISE, 31'($urandom_range(1000, 1 << 20)));
          cfg_write(CFG_BIAS_NOISE, 31'($urandom_range(0, 1 << 12)));
          cfg_write(CFG_BARO_NOISE, 31'($urandom_range(1000, 1 << 20)));
          cfg_write(CFG_GPSP_NOISE, 31'($urandom_range(1000, 1 << 20)));
          cfg_write(CFG_GPSV_NOISE, 31'($urandom_range(1000, 1 << 20)));
        end
      endcase
      cfg_we <= 1'b0;
      @(negedge clk);
      rx_mode <= ph % 3;
      gaps_on = (ph != 4);
      send_req(mk_req(OPC_INIT, 32'(jitter(2000)), 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
      burst = $urandom_range(1, 8);
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 40) hold_seq <= hold_seq + 1;
        rq = random_req();
        send_req(rq, 1'b0, none);
        burst--;
        if (burst == 0) begin
          if (gaps_on) send_gap();
          burst = $urandom_range(1, 8);
        end
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/akf_pkg.sv
design/akf_div.sv
design/altitude_kalman_filter_top.sv
verif/tb.sv
